[rtl/core/vdl2_pkg.sv]
// ----------------------------------------------------------------------------
// vdl2_pkg: shared types and constants of the vector distance engine
// Element and lane sizes, queue depths, operation and register codes.
// ----------------------------------------------------------------------------
package vdl2_pkg;

	localparam int LANE_COUNT    = 8;
	localparam int ELEMENT_WIDTH = 16;
	localparam int MAX_GROUPS    = 128;

	localparam int GIDX_W = 7;
	localparam int GRP_W  = $clog2(MAX_GROUPS);
	localparam int DIST_W = 48;

	localparam int DIFF_W = ELEMENT_WIDTH + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int PSUM_W = PROD_W + $clog2(LANE_COUNT) + 1;
	localparam int ACC_W  = DIST_W + 2;

	localparam int MIDQ_DEPTH  = 4;
	localparam int MIDQ_PTR_W  = $clog2(MIDQ_DEPTH);
	localparam int MIDQ_CNT_W  = $clog2(MIDQ_DEPTH + 1);
	localparam int OUTQ_DEPTH  = 16;
	localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ACCUM = 1'b1;

	localparam logic METRIC_L2  = 1'b0;
	localparam logic METRIC_DOT = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_METRIC = '0;

	localparam logic signed [DIST_W-1:0] SUM_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] SUM_MIN = {1'b1, {(DIST_W-1){1'b0}}};

	typedef logic [LANE_COUNT-1:0][ELEMENT_WIDTH-1:0] lanes_t;

	typedef struct packed {
		logic             op;
		logic [GRP_W-1:0] grp;
		lanes_t           lanes;
		logic             fin;
		logic             emits;
	} item_t;

	typedef struct packed {
		logic              vld;
		logic [DIST_W-1:0] value;
	} res_t;

endpackage

[rtl/core/vdl2_front.sv]
// ----------------------------------------------------------------------------
// vdl2_front: item intake
// Classifies incoming items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module vdl2_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic                         operation,
	input  logic [vdl2_pkg::GIDX_W-1:0]  group_index,
	input  vdl2_pkg::lanes_t             lanes,
	input  logic                         final_group,
	input  logic                         issue,
	output logic                         full,
	output logic                         head_valid,
	output vdl2_pkg::item_t              head
);

	vdl2_pkg::item_t                     item_in;
	vdl2_pkg::item_t                     queue_q [vdl2_pkg::MIDQ_DEPTH];
	logic [vdl2_pkg::MIDQ_PTR_W-1:0]     wr_ptr_q;
	logic [vdl2_pkg::MIDQ_PTR_W-1:0]     rd_ptr_q;
	logic [vdl2_pkg::MIDQ_CNT_W-1:0]     cnt_q;
	logic                                do_push;

	always_comb begin
		item_in.op    = operation;
		item_in.grp   = group_index[vdl2_pkg::GRP_W-1:0];
		item_in.lanes = lanes;
		item_in.fin   = final_group;
		item_in.emits = (operation == vdl2_pkg::OP_ACCUM) && final_group;
	end

	assign full       = (cnt_q == vdl2_pkg::MIDQ_CNT_W'(vdl2_pkg::MIDQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = queue_q[rd_ptr_q];
	assign do_push    = push && !full;

	always_ff @(posedge clk) begin
		if (do_push) begin
			queue_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, issue})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/vdl2_back.sv]
// ----------------------------------------------------------------------------
// vdl2_back: query store and distance datapath
// Holds the query groups, forms the lane terms, folds them into a saturating
// running sum and emits finished distances.
// ----------------------------------------------------------------------------
module vdl2_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            metric,
	input  logic                            head_valid,
	input  vdl2_pkg::item_t                 head,
	input  logic [vdl2_pkg::OUTQ_CNT_W-1:0] outq_cnt,
	output logic                            issue,
	output vdl2_pkg::res_t                  res
);

	localparam logic signed [vdl2_pkg::PSUM_W-1:0] PZero = '0;

	typedef logic signed [vdl2_pkg::PSUM_W-1:0] psum_t;
	typedef logic signed [vdl2_pkg::PROD_W-1:0] prod_t;
	typedef logic signed [vdl2_pkg::DIST_W-1:0] dist_t;
	typedef logic signed [vdl2_pkg::ACC_W-1:0]  acc_t;

	typedef struct packed {
		logic vld;
		logic fin;
	} ctl_t;

	function automatic psum_t smax(input psum_t x, input psum_t y);
		return (x > y) ? x : y;
	endfunction

	function automatic psum_t smin(input psum_t x, input psum_t y);
		return (x < y) ? x : y;
	endfunction

	logic [vdl2_pkg::LANE_COUNT*vdl2_pkg::ELEMENT_WIDTH-1:0] qmem [vdl2_pkg::MAX_GROUPS];

	logic [vdl2_pkg::OUTQ_CNT_W-1:0] infl_q;
	logic                            room;
	logic                            wr_load;
	logic                            rd_accum;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;

	vdl2_pkg::lanes_t lanes_s1;
	vdl2_pkg::lanes_t qry_s1;

	prod_t opa [vdl2_pkg::LANE_COUNT];
	prod_t opb [vdl2_pkg::LANE_COUNT];
	prod_t prod_s2 [vdl2_pkg::LANE_COUNT];
	psum_t pair_s3 [vdl2_pkg::LANE_COUNT/2];
	psum_t even_s3 [vdl2_pkg::LANE_COUNT/2];
	psum_t half_s4 [vdl2_pkg::LANE_COUNT/2];
	psum_t even_s4 [vdl2_pkg::LANE_COUNT/2];
	psum_t pre_s5  [vdl2_pkg::LANE_COUNT];
	psum_t mx_s6 [2];
	psum_t mn_s6 [2];
	psum_t tot_s6, tot_s7, tot_s8;
	psum_t mxp_s7, mnp_s7, mxp_s8, mnp_s8;
	dist_t hi_s8, lo_s8;

	dist_t sum_q;
	acc_t  x_hi, x_lo, x_tot;
	dist_t sum_nxt;
	dist_t dist_out;

	assign room = ({1'b0, outq_cnt} + {1'b0, infl_q})
		< (vdl2_pkg::OUTQ_CNT_W + 1)'(vdl2_pkg::OUTQ_DEPTH);
	assign issue    = head_valid && (!head.emits || room);
	assign wr_load  = issue && (head.op == vdl2_pkg::OP_LOAD);
	assign rd_accum = issue && (head.op == vdl2_pkg::OP_ACCUM);

	always_ff @(posedge clk) begin
		if (wr_load) begin
			qmem[head.grp] <= head.lanes;
		end
		if (rd_accum) begin
			qry_s1 <= qmem[head.grp];
		end
	end

	always_comb begin
		for (int k = 0; k < vdl2_pkg::LANE_COUNT; k++) begin
			logic signed [vdl2_pkg::DIFF_W-1:0] se;
			logic signed [vdl2_pkg::DIFF_W-1:0] qe;
			logic signed [vdl2_pkg::DIFF_W-1:0] df;
			se = {lanes_s1[k][vdl2_pkg::ELEMENT_WIDTH-1], lanes_s1[k]};
			qe = {qry_s1[k][vdl2_pkg::ELEMENT_WIDTH-1], qry_s1[k]};
			df = se - qe;
			if (metric == vdl2_pkg::METRIC_DOT) begin
				opa[k] = vdl2_pkg::PROD_W'(se);
				opb[k] = vdl2_pkg::PROD_W'(qe);
			end else begin
				opa[k] = vdl2_pkg::PROD_W'(df);
				opb[k] = vdl2_pkg::PROD_W'(df);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_accum) begin
			lanes_s1 <= head.lanes;
		end
		for (int k = 0; k < vdl2_pkg::LANE_COUNT; k++) begin
			prod_s2[k] <= opa[k] * opb[k];
		end
		for (int i = 0; i < vdl2_pkg::LANE_COUNT/2; i++) begin
			pair_s3[i] <= vdl2_pkg::PSUM_W'(prod_s2[2*i]) + vdl2_pkg::PSUM_W'(prod_s2[2*i+1]);
			even_s3[i] <= vdl2_pkg::PSUM_W'(prod_s2[2*i]);
			even_s4[i] <= even_s3[i];
		end
		half_s4[0] <= pair_s3[0];
		half_s4[1] <= pair_s3[0] + pair_s3[1];
		half_s4[2] <= (pair_s3[0] + pair_s3[1]) + pair_s3[2];
		half_s4[3] <= (pair_s3[0] + pair_s3[1]) + (pair_s3[2] + pair_s3[3]);
		for (int i = 0; i < vdl2_pkg::LANE_COUNT/2; i++) begin
			pre_s5[2*i+1] <= half_s4[i];
			pre_s5[2*i]   <= ((i == 0) ? PZero : half_s4[(i == 0) ? 0 : i-1]) + even_s4[i];
		end
		mx_s6[0] <= smax(smax(PZero, pre_s5[0]), smax(pre_s5[1], pre_s5[2]));
		mx_s6[1] <= smax(smax(pre_s5[3], pre_s5[4]), smax(pre_s5[5], pre_s5[6]));
		mn_s6[0] <= smin(smin(PZero, pre_s5[0]), smin(pre_s5[1], pre_s5[2]));
		mn_s6[1] <= smin(smin(pre_s5[3], pre_s5[4]), smin(pre_s5[5], pre_s5[6]));
		tot_s6   <= pre_s5[7];
		mxp_s7   <= smax(smax(mx_s6[0], mx_s6[1]), tot_s6);
		mnp_s7   <= smin(smin(mn_s6[0], mn_s6[1]), tot_s6);
		tot_s7   <= tot_s6;
		mxp_s8   <= mxp_s7;
		mnp_s8   <= mnp_s7;
		tot_s8   <= tot_s7;
		hi_s8    <= vdl2_pkg::DIST_W'(acc_t'(vdl2_pkg::SUM_MAX) + acc_t'(tot_s7) - acc_t'(mxp_s7));
		lo_s8    <= vdl2_pkg::DIST_W'(acc_t'(vdl2_pkg::SUM_MIN) + acc_t'(tot_s7) - acc_t'(mnp_s7));
	end

	always_comb begin
		x_hi  = acc_t'(sum_q) + acc_t'(mxp_s8);
		x_lo  = acc_t'(sum_q) + acc_t'(mnp_s8);
		x_tot = acc_t'(sum_q) + acc_t'(tot_s8);
		if (x_hi > acc_t'(vdl2_pkg::SUM_MAX)) begin
			sum_nxt = hi_s8;
		end else if (x_lo < acc_t'(vdl2_pkg::SUM_MIN)) begin
			sum_nxt = lo_s8;
		end else begin
			sum_nxt = vdl2_pkg::DIST_W'(x_tot);
		end
		if (metric == vdl2_pkg::METRIC_DOT) begin
			dist_out = (sum_nxt == vdl2_pkg::SUM_MIN) ? vdl2_pkg::SUM_MAX : -sum_nxt;
		end else begin
			dist_out = sum_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			ctl_s3    <= '0;
			ctl_s4    <= '0;
			ctl_s5    <= '0;
			ctl_s6    <= '0;
			ctl_s7    <= '0;
			ctl_s8    <= '0;
			sum_q     <= '0;
			infl_q    <= '0;
			res.vld   <= 1'b0;
			res.value <= '0;
		end else begin
			ctl_s1.vld <= rd_accum;
			ctl_s1.fin <= head.fin;
			ctl_s2     <= ctl_s1;
			ctl_s3     <= ctl_s2;
			ctl_s4     <= ctl_s3;
			ctl_s5     <= ctl_s4;
			ctl_s6     <= ctl_s5;
			ctl_s7     <= ctl_s6;
			ctl_s8     <= ctl_s7;
			res.vld    <= ctl_s8.vld && ctl_s8.fin;
			if (ctl_s8.vld) begin
				sum_q <= ctl_s8.fin ? '0 : sum_nxt;
				if (ctl_s8.fin) begin
					res.value <= dist_out;
				end
			end
			case ({issue && head.emits, res.vld})
				2'b10:   infl_q <= infl_q + 1'b1;
				2'b01:   infl_q <= infl_q - 1'b1;
				default: infl_q <= infl_q;
			endcase
		end
	end

endmodule

[rtl/core/vdl2_outq.sv]
// ----------------------------------------------------------------------------
// vdl2_outq: result queue
// Buffers finished distances until the consumer takes them.
// ----------------------------------------------------------------------------
module vdl2_outq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vdl2_pkg::res_t                  res,
	input  logic                            pop,
	output logic                            empty,
	output logic [vdl2_pkg::DIST_W-1:0]     distance,
	output logic [vdl2_pkg::OUTQ_CNT_W-1:0] cnt
);

	logic [vdl2_pkg::DIST_W-1:0]     oq_q [vdl2_pkg::OUTQ_DEPTH];
	logic [vdl2_pkg::OUTQ_PTR_W-1:0] wr_ptr_q;
	logic [vdl2_pkg::OUTQ_PTR_W-1:0] rd_ptr_q;
	logic [vdl2_pkg::OUTQ_CNT_W-1:0] cnt_q;
	logic                            do_pop;

	assign empty    = (cnt_q == '0);
	assign distance = oq_q[rd_ptr_q];
	assign cnt      = cnt_q;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (res.vld) begin
			oq_q[wr_ptr_q] <= res.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res.vld) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({res.vld, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/vector_distance_l2_or_dot.sv]
// ----------------------------------------------------------------------------
// vector_distance_l2_or_dot: squared Euclidean distance / inner product engine
// Top level: configuration register, item intake, datapath and result queue.
// ----------------------------------------------------------------------------
// Load the query with operation 0 items, one group of eight elements each,
// then stream stored vectors with operation 1 items; the item flagged as the
// final group produces one distance (negated inner product when metric_select
// is 1). A new item is accepted each clock while the result queue has room.
// Each distance passes through the eight-stage datapath (query store read,
// lane multipliers, prefix-sum tree, saturating fold) after its final group
// is accepted. Intake pauses only while sixteen results are queued or in
// flight. Write metric_select only while the block is idle.
module vector_distance_l2_or_dot (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [vdl2_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [vdl2_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [vdl2_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	input  logic                               push,
	output logic                               full,
	input  logic                               operation,
	input  logic [vdl2_pkg::GIDX_W-1:0]        group_index,
	input  logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_0,
	input  logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_1,
	input  logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_2,
	input  logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_3,
	input  logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_4,
	input  logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_5,
	input  logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_6,
	input  logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_7,
	input  logic                               final_group,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [vdl2_pkg::DIST_W-1:0] distance
);

	logic                            metric_q;
	logic [vdl2_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                            cfg_wr;
	vdl2_pkg::lanes_t                lanes;
	vdl2_pkg::item_t                 head;
	logic                            head_valid;
	logic                            issue;
	vdl2_pkg::res_t                  res;
	logic [vdl2_pkg::OUTQ_CNT_W-1:0] outq_cnt;
	logic [vdl2_pkg::DIST_W-1:0]     dist_raw;

	assign pready  = 1'b1;
	assign reg_idx = paddr[vdl2_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == vdl2_pkg::REG_METRIC)
		? {{(vdl2_pkg::APB_DATA_W-1){1'b0}}, metric_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= vdl2_pkg::METRIC_L2;
		end else if (cfg_wr && (reg_idx == vdl2_pkg::REG_METRIC)) begin
			metric_q <= pwdata[0];
		end
	end

	assign lanes = {lane_7, lane_6, lane_5, lane_4, lane_3, lane_2, lane_1, lane_0};

	vdl2_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.operation   (operation),
		.group_index (group_index),
		.lanes       (lanes),
		.final_group (final_group),
		.issue       (issue),
		.full        (full),
		.head_valid  (head_valid),
		.head        (head)
	);

	vdl2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.metric     (metric_q),
		.head_valid (head_valid),
		.head       (head),
		.outq_cnt   (outq_cnt),
		.issue      (issue),
		.res        (res)
	);

	vdl2_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.pop      (pop),
		.empty    (empty),
		.distance (dist_raw),
		.cnt      (outq_cnt)
	);

	assign distance = $signed(dist_raw);

endmodule

[rtl/core/vdl2_checker.sv]
// ----------------------------------------------------------------------------
// vdl2_checker: port-level checks of the distance engine
// Watches both queue interfaces and is bound to the top level.
// ----------------------------------------------------------------------------
module vdl2_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               push,
	input logic                               full,
	input logic                               empty,
	input logic                               pop,
	input logic signed [vdl2_pkg::DIST_W-1:0] distance
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("pending result dropped without a transfer");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(distance))
		else $error("pending distance changed without a transfer");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("intake filled without an input transfer");

	a_empty_needs_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result queue drained without a pop");

endmodule

bind vector_distance_l2_or_dot vdl2_checker u_vdl2_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.distance (distance)
);

[verif/tb_vector_distance_l2_or_dot.sv]
// ----------------------------------------------------------------------------
// tb_vector_distance_l2_or_dot: self-checking bench of the distance engine
// Loads query groups and streams stored vectors in both metrics through the
// push/pop queues, with a directed table, long vectors at the element extremes
// and random traffic; every popped distance is compared with an in-bench
// predictor or with the value given in the directed table.
// ----------------------------------------------------------------------------
module tb_vector_distance_l2_or_dot;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 32;
	localparam int STALL_LIMIT    = 5000;
	localparam int PRINT_LIMIT    = 40;
	localparam int DIR_ROWS       = 16;
	localparam int LONG_L2_ITEMS  = 20;
	localparam int LONG_DOT_ITEMS = 20;
	localparam int PHASE_ITEMS    = 210;

	localparam logic [vdl2_pkg::APB_ADDR_W-1:0] METRIC_ADDR   = {vdl2_pkg::REG_METRIC, 2'b00};
	localparam logic [vdl2_pkg::APB_ADDR_W-1:0] UNMAPPED_ADDR = vdl2_pkg::APB_ADDR_W'(4);

	localparam longint SUM_MAX_L = longint'(vdl2_pkg::SUM_MAX);
	localparam longint SUM_MIN_L = longint'(vdl2_pkg::SUM_MIN);

	typedef struct packed {
		logic                        op;
		logic [vdl2_pkg::GIDX_W-1:0] grp;
		vdl2_pkg::lanes_t            lanes;
		logic                        fin;
	} stim_t;

	typedef struct packed {
		logic                               metric;
		stim_t                              item;
		logic                               known;
		logic signed [vdl2_pkg::DIST_W-1:0] value;
	} dir_row_t;

	typedef enum {POP_ALWAYS, POP_COIN, POP_EVERY4, POP_SPARSE} pop_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [vdl2_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [vdl2_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [vdl2_pkg::APB_DATA_W-1:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic operation = vdl2_pkg::OP_LOAD;
	logic [vdl2_pkg::GIDX_W-1:0] group_index = '0;
	logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_0 = '0;
	logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_1 = '0;
	logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_2 = '0;
	logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_3 = '0;
	logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_4 = '0;
	logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_5 = '0;
	logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_6 = '0;
	logic signed [vdl2_pkg::ELEMENT_WIDTH-1:0] lane_7 = '0;
	logic final_group = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [vdl2_pkg::DIST_W-1:0] distance;

	vector_distance_l2_or_dot uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .operation(operation), .group_index(group_index),
		.lane_0(lane_0), .lane_1(lane_1), .lane_2(lane_2), .lane_3(lane_3),
		.lane_4(lane_4), .lane_5(lane_5), .lane_6(lane_6), .lane_7(lane_7),
		.final_group(final_group), .empty(empty), .pop(pop), .distance(distance)
	);

	vdl2_pkg::lanes_t query_mem [vdl2_pkg::MAX_GROUPS];
	bit     query_loaded [vdl2_pkg::MAX_GROUPS];
	int     loaded_groups [$];
	longint run_sum = 0;
	logic   dot_mode = vdl2_pkg::METRIC_L2;

	logic signed [vdl2_pkg::DIST_W-1:0] pending_distances [$];

	int fail_count = 0;
	int burst_left = 0;
	int stall_cycles = 0;
	bit hold_off_req = 0;
	int hold_left = 0;
	int mode_left = 0;
	pop_mode_t pop_mode = POP_ALWAYS;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{vdl2_pkg::METRIC_L2, '{vdl2_pkg::OP_LOAD, 7'd0, {8{16'h0000}}, 1'b0},
			1'b1, 48'sd0},
		'{vdl2_pkg::METRIC_L2, '{vdl2_pkg::OP_ACCUM, 7'd0, {8{16'h0000}}, 1'b1},
			1'b1, 48'sd0},
		'{vdl2_pkg::METRIC_L2, '{vdl2_pkg::OP_LOAD, 7'd127, {8{16'h8000}}, 1'b0},
			1'b0, 48'sd0},
		'{vdl2_pkg::METRIC_L2, '{vdl2_pkg::OP_ACCUM, 7'd127, {8{16'h7fff}}, 1'b1},
			1'b1, 48'sd34358689800},
		'{vdl2_pkg::METRIC_L2, '{vdl2_pkg::OP_LOAD, 7'd1, {8{16'h7fff}}, 1'b0},
			1'b0, 48'sd0},
		'{vdl2_pkg::METRIC_L2, '{vdl2_pkg::OP_LOAD, 7'd1, {8{16'h0001}}, 1'b1},
			1'b0, 48'sd0},
		'{vdl2_pkg::METRIC_L2, '{vdl2_pkg::OP_ACCUM, 7'd1, {8{16'h0001}}, 1'b0},
			1'b0, 48'sd0},
		'{vdl2_pkg::METRIC_L2, '{vdl2_pkg::OP_ACCUM, 7'd0, {8{16'h0003}}, 1'b1},
			1'b1, 48'sd72},
		'{vdl2_pkg::METRIC_L2, '{vdl2_pkg::OP_LOAD, 7'd2, {16'h0001, 16'hffff, 16'h0002,
			16'hfffe, 16'h1234, 16'hedcb, 16'h7fff, 16'h8000}, 1'b0}, 1'b0, 48'sd0},
		'{vdl2_pkg::METRIC_L2, '{vdl2_pkg::OP_ACCUM, 7'd2, {8{16'h8000}}, 1'b0},
			1'b0, 48'sd0},
		'{vdl2_pkg::METRIC_L2, '{vdl2_pkg::OP_ACCUM, 7'd127, {8{16'h8000}}, 1'b1},
			1'b0, 48'sd0},
		'{vdl2_pkg::METRIC_DOT, '{vdl2_pkg::OP_ACCUM, 7'd127, {8{16'h8000}}, 1'b1},
			1'b1, -48'sd8589934592},
		'{vdl2_pkg::METRIC_DOT, '{vdl2_pkg::OP_ACCUM, 7'd127, {8{16'h7fff}}, 1'b1},
			1'b1, 48'sd8589672448},
		'{vdl2_pkg::METRIC_DOT, '{vdl2_pkg::OP_ACCUM, 7'd0, {8{16'h7fff}}, 1'b1},
			1'b1, 48'sd0},
		'{vdl2_pkg::METRIC_DOT, '{vdl2_pkg::OP_ACCUM, 7'd2, {16'h5555, 16'haaaa, 16'h00ff,
			16'hff00, 16'h0f0f, 16'hf0f0, 16'h3333, 16'hcccc}, 1'b0}, 1'b0, 48'sd0},
		'{vdl2_pkg::METRIC_DOT, '{vdl2_pkg::OP_ACCUM, 7'd1, {8{16'hffff}}, 1'b1},
			1'b0, 48'sd0}
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what,
		input logic [vdl2_pkg::DIST_W-1:0] got, input logic [vdl2_pkg::DIST_W-1:0] want);
		if (fail_count < PRINT_LIMIT) begin
			$display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what,
				$signed(got), $signed(want));
		end
		fail_count++;
	endtask

	task automatic compute_distance(input stim_t it, output bit emits,
		output logic signed [vdl2_pkg::DIST_W-1:0] dist_val);
		longint s;
		longint q;
		longint term;
		longint res;
		emits = 0;
		dist_val = '0;
		if (it.op == vdl2_pkg::OP_LOAD) begin
			query_mem[it.grp] = it.lanes;
			if (!query_loaded[it.grp]) begin
				query_loaded[it.grp] = 1;
				loaded_groups.push_back(int'(it.grp));
			end
		end else begin
			for (int k = 0; k < vdl2_pkg::LANE_COUNT; k++) begin
				s = longint'($signed(it.lanes[k]));
				q = longint'($signed(query_mem[it.grp][k]));
				term = (dot_mode == vdl2_pkg::METRIC_DOT) ? s * q : (s - q) * (s - q);
				run_sum = run_sum + term;
				if (run_sum > SUM_MAX_L) run_sum = SUM_MAX_L;
				if (run_sum < SUM_MIN_L) run_sum = SUM_MIN_L;
			end
			if (it.fin) begin
				res = run_sum;
				if (dot_mode == vdl2_pkg::METRIC_DOT) begin
					res = (res == SUM_MIN_L) ? SUM_MAX_L : -res;
				end
				dist_val = res[vdl2_pkg::DIST_W-1:0];
				emits = 1;
				run_sum = 0;
			end
		end
	endtask

	task automatic send_item(input stim_t it, input bit typed,
		input logic signed [vdl2_pkg::DIST_W-1:0] typed_dist);
		bit emits;
		logic signed [vdl2_pkg::DIST_W-1:0] dist_val;
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		operation   <= it.op;
		group_index <= it.grp;
		lane_0      <= it.lanes[0];
		lane_1      <= it.lanes[1];
		lane_2      <= it.lanes[2];
		lane_3      <= it.lanes[3];
		lane_4      <= it.lanes[4];
		lane_5      <= it.lanes[5];
		lane_6      <= it.lanes[6];
		lane_7      <= it.lanes[7];
		final_group <= it.fin;
		push        <= 1'b1;
		do @(posedge clk); while (full !== 1'b0);
		burst_left--;
		compute_distance(it, emits, dist_val);
		if (emits) pending_distances.push_back(typed ? typed_dist : dist_val);
	endtask

	task automatic settle();
		push <= 1'b0;
		burst_left = 0;
		while (pending_distances.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [vdl2_pkg::APB_ADDR_W-1:0] addr,
		input logic [vdl2_pkg::APB_DATA_W-1:0] wdata,
		output logic [vdl2_pkg::APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_metric();
		logic [vdl2_pkg::APB_DATA_W-1:0] rd;
		apb_access(1'b0, METRIC_ADDR, '0, rd);
		if (rd !== vdl2_pkg::APB_DATA_W'(dot_mode)) begin
			report_mismatch("metric_select readback", vdl2_pkg::DIST_W'(rd),
				vdl2_pkg::DIST_W'(dot_mode));
		end
	endtask

	task automatic set_metric(input logic m);
		logic [vdl2_pkg::APB_DATA_W-1:0] rd;
		settle();
		apb_access(1'b1, METRIC_ADDR, vdl2_pkg::APB_DATA_W'(m), rd);
		dot_mode = m;
		check_metric();
	endtask

	function automatic vdl2_pkg::lanes_t rand_lanes();
		vdl2_pkg::lanes_t l;
		for (int k = 0; k < vdl2_pkg::LANE_COUNT; k++) begin
			case ($urandom_range(0, 9))
				0: l[k] = 16'h8000;
				1: l[k] = 16'h7fff;
				2: l[k] = 16'h0000;
				3: l[k] = 16'hffff;
				default: l[k] = 16'($urandom);
			endcase
		end
		return l;
	endfunction

	function automatic logic [vdl2_pkg::GIDX_W-1:0] pick_group();
		return vdl2_pkg::GIDX_W'(loaded_groups[$urandom_range(0, loaded_groups.size() - 1)]);
	endfunction

	always @(posedge clk) begin
		if (hold_left != 0) begin
			pop <= 1'b0;
			hold_left--;
		end else if (hold_off_req) begin
			hold_off_req = 0;
			hold_left = HOLD_CYCLES;
			pop <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				pop_mode = pop_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 150);
			end
			mode_left--;
			case (pop_mode)
				POP_ALWAYS: pop <= 1'b1;
				POP_COIN:   pop <= 1'($urandom_range(0, 1));
				POP_EVERY4: pop <= (mode_left % 4 == 0);
				default:    pop <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop === 1'b1 && empty === 1'b0) begin
			if (pending_distances.size() == 0) begin
				report_mismatch("unexpected distance", distance, 'x);
			end else if (distance !== pending_distances[0]) begin
				report_mismatch("distance", distance, pending_distances.pop_front());
			end else begin
				void'(pending_distances.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((push && full === 1'b0) || (pop && empty === 1'b0) || (psel && penable)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("** vector_distance_l2_or_dot: FAILED **");
			$finish;
		end
	end

	initial begin
		stim_t it;
		logic [vdl2_pkg::APB_DATA_W-1:0] rd;
		int sent;
		int len;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_metric();
		apb_access(1'b1, UNMAPPED_ADDR, '1, rd);
		check_metric();

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].metric != dot_mode) set_metric(dir_rows[i].metric);
			send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].value);
		end

		for (int phase = 0; phase < 6; phase++) begin
			set_metric((phase % 2 == 1) ? vdl2_pkg::METRIC_DOT : vdl2_pkg::METRIC_L2);
			if (phase == 2) begin
				hold_off_req = 1;
				repeat (60) begin
					send_item('{vdl2_pkg::OP_ACCUM, pick_group(), rand_lanes(), 1'b1},
						0, '0);
				end
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 6)) begin
						send_item('{vdl2_pkg::OP_LOAD, vdl2_pkg::GIDX_W'($urandom),
							rand_lanes(), 1'($urandom_range(0, 1))}, 0, '0);
						sent++;
					end
				end else begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
					for (int j = 0; j < len; j++) begin
						if ($urandom_range(0, 19) == 0) begin
							send_item('{vdl2_pkg::OP_LOAD, vdl2_pkg::GIDX_W'($urandom),
								rand_lanes(), 1'($urandom_range(0, 1))}, 0, '0);
							sent++;
						end
						it = '{vdl2_pkg::OP_ACCUM, pick_group(), rand_lanes(),
							1'(j == len - 1)};
						send_item(it, 0, '0);
						sent++;
					end
				end
			end
		end

		set_metric(vdl2_pkg::METRIC_L2);
		send_item('{vdl2_pkg::OP_LOAD, 7'd127, {8{16'h8000}}, 1'b0}, 0, '0);
		for (int j = 0; j < LONG_L2_ITEMS; j++) begin
			send_item('{vdl2_pkg::OP_ACCUM, 7'd127, {8{16'h7fff}},
				1'(j == LONG_L2_ITEMS - 1)}, 0, '0);
		end
		set_metric(vdl2_pkg::METRIC_DOT);
		for (int j = 0; j < LONG_DOT_ITEMS + 10; j++) begin
			it = '{vdl2_pkg::OP_ACCUM, 7'd127,
				(j < LONG_DOT_ITEMS) ? {8{16'h7fff}} : {8{16'h8000}},
				1'(j == LONG_DOT_ITEMS + 9)};
			send_item(it, 0, '0);
		end

		settle();
		if (fail_count == 0) begin
			$display("** vector_distance_l2_or_dot: PASSED **");
		end else begin
			$display("** vector_distance_l2_or_dot: FAILED **");
		end
		$finish;
	end

endmodule
